// ===== rtl/luhn_pkg.sv =====
// Shared types, constants and helper functions for the Luhn card number checker.
// No dependencies; imported by every module in rtl/.
package luhn_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned LEAD_DEPTH  = 4;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'd57;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd20;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 5'd13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd19;

    // Card kind codes as they appear on the result
    typedef enum logic [2:0] {
        KIND_UNKNOWN    = 3'd0,
        KIND_VISA       = 3'd1,
        KIND_MASTERCARD = 3'd2,
        KIND_AMEX       = 3'd3,
        KIND_DISCOVER   = 3'd4
    } card_kind_t;

    // Digit state after taking one character, as seen by the classifier
    typedef struct packed {
        logic [COUNT_W-1:0]                    count;
        logic [DIGIT_W-1:0]                    sum;
        logic [LEAD_DEPTH-1:0][DIGIT_W-1:0]    lead;
    } luhn_summary_t;

    // Luhn doubling: 2d, less 9 when above 9
    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t > 5'd9)
            t = t - 5'd9;
        return t[DIGIT_W-1:0];
    endfunction

    // Add two values below ten, modulo ten
    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= 5'd10)
            t = t - 5'd10;
        return t[DIGIT_W-1:0];
    endfunction

endpackage

// ===== rtl/luhn_accum.sv =====
// Running Luhn sums for both doubling phases, saturating digit count, first four digits.
// Depends on luhn_pkg.
module luhn_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [luhn_pkg::CHAR_W-1:0]         char_code,
    input  logic                                end_of_number,
    input  logic                                take,
    output luhn_pkg::luhn_summary_t             summary
);
    import luhn_pkg::*;

    logic [DIGIT_W-1:0]                 sum_even_reg, sum_even_next;
    logic [DIGIT_W-1:0]                 sum_odd_reg, sum_odd_next;
    logic [COUNT_W-1:0]                 count_reg, count_next;
    logic [LEAD_DEPTH-1:0][DIGIT_W-1:0] lead_reg, lead_next;

    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] digit_dbl;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit     = char_code[DIGIT_W-1:0];
    assign digit_dbl = luhn_double(digit);

    // Fold the character into both phase sums, count and prefix
    always_comb
    begin
        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        count_next    = count_reg;
        lead_next     = lead_reg;
        if (is_digit)
        begin
            if (!count_reg[0])
            begin
                sum_even_next = add_mod10(sum_even_reg, digit_dbl);
                sum_odd_next  = add_mod10(sum_odd_reg, digit);
            end
            else
            begin
                sum_even_next = add_mod10(sum_even_reg, digit);
                sum_odd_next  = add_mod10(sum_odd_reg, digit_dbl);
            end
            if (count_reg < COUNT_W'(LEAD_DEPTH))
                lead_next[count_reg[1:0]] = digit;
            if (count_reg < COUNT_SAT)
                count_next = count_reg + 1'b1;
        end
    end

    // Doubled positions share the parity of the digit count
    assign summary.count = count_next;
    assign summary.sum   = count_next[0] ? sum_odd_next : sum_even_next;
    assign summary.lead  = lead_next;

    // Advance on each request; clear after the last character of a number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            count_reg    <= '0;
            lead_reg     <= '0;
        end
        else if (take)
        begin
            if (end_of_number)
            begin
                sum_even_reg <= '0;
                sum_odd_reg  <= '0;
                count_reg    <= '0;
                lead_reg     <= '0;
            end
            else
            begin
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
                count_reg    <= count_next;
                lead_reg     <= lead_next;
            end
        end
    end

endmodule

// ===== rtl/luhn_classify.sv =====
// Validity check and card kind prefix rules on a finished digit summary.
// Depends on luhn_pkg.
module luhn_classify (
    input  luhn_pkg::luhn_summary_t summary,
    output logic                    number_valid,
    output luhn_pkg::card_kind_t    card_kind
);
    import luhn_pkg::*;

    logic [6:0]  two;
    logic [13:0] four;
    logic        has1, has2, has4;

    assign two  = 7'(summary.lead[0]) * 7'd10 + 7'(summary.lead[1]);
    assign four = 14'(two) * 14'd100 + 14'(summary.lead[2]) * 14'd10
                + 14'(summary.lead[3]);
    assign has1 = summary.count >= 5'd1;
    assign has2 = summary.count >= 5'd2;
    assign has4 = summary.count >= 5'd4;

    assign number_valid = (summary.count >= COUNT_MIN) && (summary.count <= COUNT_MAX)
                        && (summary.sum == '0);

    // Prefix rules, first match wins
    always_comb
    begin
        priority if (has1 && summary.lead[0] == 4'd4)
            card_kind = KIND_VISA;
        else if (has2 && two >= 7'd51 && two <= 7'd55)
            card_kind = KIND_MASTERCARD;
        else if (has4 && four >= 14'd2221 && four <= 14'd2720)
            card_kind = KIND_MASTERCARD;
        else if (has2 && (two == 7'd34 || two == 7'd37))
            card_kind = KIND_AMEX;
        else if (has4 && four == 14'd6011)
            card_kind = KIND_DISCOVER;
        else if (has2 && two == 7'd65)
            card_kind = KIND_DISCOVER;
        else
            card_kind = KIND_UNKNOWN;
    end

endmodule

// ===== rtl/luhn_card_number_checker.sv =====
// Luhn card number checker: one ASCII character per request, one result per number.
// Path: an accepted character is held in the input register, folded into the sums when
// it advances, and a last character's result is loaded into the m_axis result register.
// Throughput: one character every cycle, unless a last character waits for a full result slot.
// Reset (rst_n, async, active low) clears sums, count, prefix and both valid flags.
// Depends on luhn_pkg, luhn_accum, luhn_classify.
module luhn_card_number_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [luhn_pkg::CHAR_W-1:0]          s_axis_tdata,   // [7:0] char_code
    input  logic                                 s_axis_tlast,   // end_of_number
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [luhn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // [0] number_valid,
                                                                 // [3:1] card_kind, [7:4] 0
);
    import luhn_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              out_number_valid_reg;
    card_kind_t        out_kind_reg;

    logic              advance;
    logic              res_valid;
    card_kind_t        res_kind;
    luhn_summary_t     summary;

    // Non-last characters never need the result slot
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    luhn_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_code     (in_char_reg),
        .end_of_number (in_last_reg),
        .take          (advance),
        .summary       (summary)
    );

    luhn_classify u_classify (
        .summary      (summary),
        .number_valid (res_valid),
        .card_kind    (res_kind)
    );

    // Result register: load on the last character, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_number_valid_reg <= res_valid;
            out_kind_reg         <= res_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_kind_reg, out_number_valid_reg};

endmodule
